@@ design/assert_macros.svh @@
// Assertion macros shared by the edge locator RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CSEL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define CSEL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/csel_pkg.sv @@
// Shared types and constants of the caliper step edge locator.
// No dependencies; used by the interfaces, the gradient pipeline and the top level.
package csel_pkg;

	// Field widths of the item payloads.
	localparam int SAMPLE_W = 8;
	localparam int OFFSET_W = 10;
	localparam int GRAD_W   = 13;

	// Configuration port and register widths.
	localparam int HW_CFG_W   = 5;
	localparam int THR_W      = 8;
	localparam int POL_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY       = 2'd2;

	// Polarity codes; the unused code behaves as either direction.
	localparam logic [POL_W-1:0] POL_EITHER  = 2'd0;
	localparam logic [POL_W-1:0] POL_RISING  = 2'd1;
	localparam logic [POL_W-1:0] POL_FALLING = 2'd2;

	// Register values after reset.
	localparam logic [HW_CFG_W-1:0] HALF_WINDOW_RESET    = 5'd2;
	localparam logic [THR_W-1:0]    STEP_THRESHOLD_RESET = 8'd20;
	localparam logic [POL_W-1:0]    POLARITY_RESET       = POL_EITHER;

	// Control that travels with each item down the gradient pipeline.
	typedef struct packed {
		logic valid;
		logic eval;
		logic last;
	} ctl_t;

endpackage

@@ design/csel_if.sv @@
// Valid/ready channel interfaces for samples in and edge results out.
// Depends on csel_pkg for the field widths.
interface csel_in_if;
	logic                             valid;
	logic                             ready;
	logic [csel_pkg::SAMPLE_W-1:0]    sample;
	logic                             last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface csel_out_if;
	logic                             valid;
	logic                             ready;
	logic                             edge_found;
	logic [csel_pkg::OFFSET_W-1:0]    edge_offset;
	logic signed [csel_pkg::GRAD_W-1:0] peak_gradient;
	logic                             too_short;

	modport source (output valid, output edge_found, output edge_offset,
		output peak_gradient, output too_short, input ready);
	modport sink (input valid, input edge_found, input edge_offset,
		input peak_gradient, input too_short, output ready);
endinterface

@@ design/csel_grad.sv @@
// Box step gradient pipeline: per-lane differences, grouped partial sums, total.
// Depends on csel_pkg for the sample width and the control struct.
module csel_grad #(
	parameter int MAX_HALF_WINDOW = 16,
	parameter int OFF_W = 10,
	localparam int HW = $clog2(MAX_HALF_WINDOW + 1),
	localparam int GW = $clog2(MAX_HALF_WINDOW * (2 ** csel_pkg::SAMPLE_W - 1) + 1) + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic [HW-1:0]         h_eff,
	input  logic [2*MAX_HALF_WINDOW:0][csel_pkg::SAMPLE_W-1:0] win,
	input  csel_pkg::ctl_t        ctl_in,
	input  logic [OFF_W-1:0]      off_in,
	output csel_pkg::ctl_t        ctl_out,
	output logic [OFF_W-1:0]      off_out,
	output logic signed [GW-1:0]  grad_out
);

	localparam int SW    = csel_pkg::SAMPLE_W;
	localparam int NG    = (MAX_HALF_WINDOW + 3) / 4;
	localparam int LANES = 4 * NG;
	localparam int WX    = LANES + MAX_HALF_WINDOW + 1;
	localparam int PW    = SW + 3;

	logic [WX-1:0][SW-1:0] win_x;
	logic [SW-1:0]         older [LANES];
	logic signed [SW:0]    diff [LANES];
	logic signed [SW:0]    diff_s1 [LANES];
	logic signed [PW-1:0]  part [NG];
	logic signed [PW-1:0]  part_s2 [NG];
	logic signed [GW-1:0]  total;
	logic signed [GW-1:0]  grad_s3;
	csel_pkg::ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic [OFF_W-1:0]      off_s1, off_s2, off_s3;

	// Lane j pairs the j-th newest sample with the one h+1 places older.
	// Lanes at or beyond the half window contribute nothing.
	always_comb begin
		win_x = '0;
		win_x[2*MAX_HALF_WINDOW:0] = win;
		for (int j = 0; j < LANES; j++) begin
			older[j] = '0;
			for (int k = 1; k <= MAX_HALF_WINDOW; k++) begin
				if (h_eff == HW'(k)) begin
					older[j] = win_x[j + k + 1];
				end
			end
			if (32'(h_eff) > j) begin
				diff[j] = $signed({1'b0, win_x[j]}) - $signed({1'b0, older[j]});
			end else begin
				diff[j] = '0;
			end
		end
	end

	// Partial sums over groups of four lanes.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			part[g] = '0;
			for (int i = 0; i < 4; i++) begin
				part[g] = part[g] + PW'(diff_s1[g*4 + i]);
			end
		end
	end

	// Total gradient from the group sums.
	always_comb begin
		total = '0;
		for (int g = 0; g < NG; g++) begin
			total = total + GW'(part_s2[g]);
		end
	end

	// Control flow through the three stages; the whole pipe holds on a stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Payload of the three stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= diff;
			off_s1  <= off_in;
			part_s2 <= part;
			off_s2  <= off_s1;
			grad_s3 <= total;
			off_s3  <= off_s2;
		end
	end

	assign ctl_out  = ctl_s3;
	assign off_out  = off_s3;
	assign grad_out = grad_s3;

endmodule

@@ design/caliper_step_edge_locator.sv @@
// Top level of the caliper step edge locator: window, counting, extreme tracking, output.
// Depends on csel_pkg, csel_if.sv, csel_grad and assert_macros.svh.
//
// Channel | Direction | Payload                                          | Handshake
// pix     | in        | sample, last                                     | valid/ready
// res     | out       | edge_found, edge_offset, peak_gradient, too_short | valid/ready
// cfg     | in        | cfg_index, cfg_data                              | cfg_wr_en only
//
// One sample is accepted per clock while the input is not stalled; the result of a profile
// is registered through the three gradient stages and the output register after its last
// sample is accepted. Input stalls only while a finished result sits unread in the
// output register and the next one has reached the end of the gradient pipeline.
// Reset clears the configuration to its defaults and empties the pipeline.
`include "assert_macros.svh"

module caliper_step_edge_locator #(
	parameter int MAX_HALF_WINDOW = 16,
	parameter int MAX_PROFILE_LEN = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [csel_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csel_pkg::CFG_DATA_W-1:0]    cfg_data,
	csel_in_if.sink                            pix,
	csel_out_if.source                         res
);

	localparam int SW    = csel_pkg::SAMPLE_W;
	localparam int HW    = $clog2(MAX_HALF_WINDOW + 1);
	localparam int GW    = $clog2(MAX_HALF_WINDOW * (2 ** SW - 1) + 1) + 1;
	localparam int CW    = $clog2(MAX_PROFILE_LEN + 1);
	localparam int OFF_W = $clog2(MAX_PROFILE_LEN);

	logic [csel_pkg::HW_CFG_W-1:0]   half_window_q;
	logic [csel_pkg::THR_W-1:0]      step_threshold_q;
	logic [csel_pkg::POL_W-1:0]      polarity_q;
	logic [HW-1:0]                   h_eff;
	logic [HW+7:0]                   thr_prod;
	logic signed [GW-1:0]            thr_q;

	logic [2*MAX_HALF_WINDOW-1:0][SW-1:0] window_q;
	logic [2*MAX_HALF_WINDOW:0][SW-1:0]   win;
	logic [CW-1:0]                   count_q;
	logic [HW:0]                     two_h;
	logic                            accept;
	logic                            adv;
	csel_pkg::ctl_t                  ctl_in;
	csel_pkg::ctl_t                  ctl_s3;
	logic [OFF_W-1:0]                off_in;
	logic [OFF_W-1:0]                off_s3;
	logic signed [GW-1:0]            grad_s3;

	logic                            best_valid_q;
	logic signed [GW-1:0]            best_grad_q;
	logic [OFF_W-1:0]                best_off_q;
	logic signed [GW-1:0]            g_mag, b_mag, nb_mag;
	logic                            better, take;
	logic                            nb_valid;
	logic signed [GW-1:0]            nb_grad;
	logic [OFF_W-1:0]                nb_off;
	logic                            found;
	logic                            load;

	logic                            res_valid_q;
	logic                            res_found_q;
	logic [csel_pkg::OFFSET_W-1:0]   res_off_q;
	logic signed [csel_pkg::GRAD_W-1:0] res_grad_q;
	logic                            res_too_short_q;
	logic                            res_blank;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q    <= csel_pkg::HALF_WINDOW_RESET;
			step_threshold_q <= csel_pkg::STEP_THRESHOLD_RESET;
			polarity_q       <= csel_pkg::POLARITY_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				csel_pkg::REG_HALF_WINDOW: begin
					half_window_q <= csel_pkg::HW_CFG_W'(cfg_data);
				end
				csel_pkg::REG_STEP_THRESHOLD: begin
					step_threshold_q <= csel_pkg::THR_W'(cfg_data);
				end
				csel_pkg::REG_POLARITY: begin
					polarity_q <= csel_pkg::POL_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// Half window clamped to one through the maximum.
	always_comb begin
		if (half_window_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(half_window_q) > MAX_HALF_WINDOW) begin
			h_eff = HW'(MAX_HALF_WINDOW);
		end else begin
			h_eff = HW'(half_window_q);
		end
	end

	// Scaled threshold is registered and follows the configuration in the next cycle.
	assign thr_prod = (HW + 8)'(h_eff) * (HW + 8)'(step_threshold_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else begin
			thr_q <= $signed(GW'(thr_prod));
		end
	end

	// Handshake: hold everything only when a second result would overwrite the first.
	assign adv       = !(ctl_s3.valid && ctl_s3.last && res_valid_q && !res.ready);
	assign pix.ready = adv;
	assign accept    = pix.valid && adv;

	// Newest sample sits at position zero of the window.
	assign win   = {window_q, pix.sample};
	assign two_h = {h_eff, 1'b0};

	// A centre is scored once 2h+1 samples of the profile are in and the cap is not reached.
	always_comb begin
		ctl_in.valid = accept;
		ctl_in.last  = pix.last;
		ctl_in.eval  = (32'(count_q) < MAX_PROFILE_LEN) && (32'(count_q) >= 32'(two_h));
		off_in       = OFF_W'(count_q - CW'(two_h));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= win[2*MAX_HALF_WINDOW-1:0];
		end
	end

	// Sample count of the current profile, saturating at the search length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (pix.last) begin
				count_q <= '0;
			end else if (32'(count_q) < MAX_PROFILE_LEN) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	csel_grad #(
		.MAX_HALF_WINDOW (MAX_HALF_WINDOW),
		.OFF_W           (OFF_W)
	) u_grad (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.h_eff    (h_eff),
		.win      (win),
		.ctl_in   (ctl_in),
		.off_in   (off_in),
		.ctl_out  (ctl_s3),
		.off_out  (off_s3),
		.grad_out (grad_s3)
	);

	// Extreme tracking by polarity; on a tie the earlier centre stays.
	always_comb begin
		g_mag = (grad_s3 < 0) ? -grad_s3 : grad_s3;
		b_mag = (best_grad_q < 0) ? -best_grad_q : best_grad_q;
		case (polarity_q)
			csel_pkg::POL_RISING: begin
				better = grad_s3 > best_grad_q;
			end
			csel_pkg::POL_FALLING: begin
				better = grad_s3 < best_grad_q;
			end
			default: begin
				better = g_mag > b_mag;
			end
		endcase
		take     = ctl_s3.eval && (!best_valid_q || better);
		nb_valid = best_valid_q || take;
		nb_grad  = take ? grad_s3 : best_grad_q;
		nb_off   = take ? off_s3 : best_off_q;
		nb_mag   = (nb_grad < 0) ? -nb_grad : nb_grad;
		case (polarity_q)
			csel_pkg::POL_RISING: begin
				found = nb_grad > thr_q;
			end
			csel_pkg::POL_FALLING: begin
				found = nb_grad < -thr_q;
			end
			default: begin
				found = nb_mag > thr_q;
			end
		endcase
	end

	assign load = adv && ctl_s3.valid && ctl_s3.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
		end else if (adv && ctl_s3.valid) begin
			best_valid_q <= nb_valid && !ctl_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s3.valid) begin
			best_grad_q <= nb_grad;
			best_off_q  <= nb_off;
		end
	end

	// Output register; a profile with no scored centre reports a blank result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_found_q     <= nb_valid && found;
			res_off_q       <= nb_valid ? csel_pkg::OFFSET_W'(nb_off) : '0;
			res_grad_q      <= nb_valid ? csel_pkg::GRAD_W'(nb_grad) : '0;
			res_too_short_q <= !nb_valid;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.edge_found    = res_found_q;
	assign res.edge_offset   = res_off_q;
	assign res.peak_gradient = res_grad_q;
	assign res.too_short     = res_too_short_q;

	// A blank result carries no edge, no offset and no gradient.
	assign res_blank = !res_found_q && res_grad_q == '0 && res_off_q == '0;

	// Checks on the block's own control.
	`CSEL_ASSERT(a_stall_needs_result, !pix.ready |-> res_valid_q, "input stalled with no result held")
	`CSEL_ASSERT(a_short_is_blank, res_valid_q && res_too_short_q |-> res_blank, "short result not blank")
	`CSEL_ASSERT_NEXT(a_profile_end_clears, load, !best_valid_q, "best not cleared at profile end")
	`CSEL_ASSERT(a_count_bound, 32'(count_q) <= MAX_PROFILE_LEN, "sample count beyond search length")

endmodule

@@ tb/tb_caliper_step_edge_locator.sv @@
// Self-checking testbench for the caliper step edge locator: directed profiles, then random ones.
// Depends on csel_pkg, the channel interfaces in csel_if.sv and the caliper_step_edge_locator top.
// Each result is checked against a cycle-free edge search model in this file or a hand result.
module tb_caliper_step_edge_locator;

	localparam int MAX_HW         = 16;
	localparam int MAX_LEN        = 1024;
	localparam int WIN_D          = 2 * MAX_HW + 1;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_SAMPLES = 200;
	localparam int PRINT_CAP      = 100;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [csel_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic                               edge_found;
		logic [csel_pkg::OFFSET_W-1:0]      edge_offset;
		logic signed [csel_pkg::GRAD_W-1:0] peak_gradient;
		logic                               too_short;
	} edge_res_t;

	typedef enum logic [2:0] {
		SH_FLAT, SH_STEP, SH_NOISE, SH_RAMP, SH_ALT, SH_SPIKE, SH_NSTEP
	} shape_t;

	// One directed profile: register values, sample pattern, optional mid-profile
	// half window change, and the result where it is known by hand.
	typedef struct packed {
		logic              keep_cfg;
		logic [7:0]        hw_data, thr_data, pol_data;
		logic [11:0]       len;
		shape_t            shape;
		logic [7:0]        lvl_a, lvl_b;
		logic [11:0]       pos;
		logic [11:0]       cut;
		logic [4:0]        cut_hw;
		logic              typed;
		edge_res_t         want;
	} plan_row_t;

	localparam int PLAN_N = 18;
	localparam plan_row_t PLAN [0:PLAN_N-1] = '{
		// Reset registers: one centre, clear rising step.
		'{1'b1, 8'd0, 8'd0, 8'd0, 12'd5, SH_STEP, 8'd10, 8'd60, 12'd2, 12'd0, 5'd0,
			1'b1, '{1'b1, 10'd0, 13'sd100, 1'b0}},
		// Short profiles at the reset half window.
		'{1'b1, 8'd0, 8'd0, 8'd0, 12'd4, SH_FLAT, 8'd0, 8'd0, 12'd0, 12'd0, 5'd0,
			1'b1, '{1'b0, 10'd0, 13'sd0, 1'b1}},
		'{1'b1, 8'd0, 8'd0, 8'd0, 12'd1, SH_FLAT, 8'd200, 8'd0, 12'd0, 12'd0, 5'd0,
			1'b1, '{1'b0, 10'd0, 13'sd0, 1'b1}},
		// Half window zero acts as one; flat profile gives zero gradient.
		'{1'b0, 8'd0, 8'd0, 8'(csel_pkg::POL_EITHER), 12'd3, SH_FLAT, 8'd255, 8'd0, 12'd0,
			12'd0, 5'd0, 1'b1, '{1'b0, 10'd0, 13'sd0, 1'b0}},
		// Full-scale step at the widest window, just at and just under the threshold.
		'{1'b0, 8'd16, 8'd255, 8'(csel_pkg::POL_RISING), 12'd33, SH_STEP, 8'd0, 8'd255,
			12'd17, 12'd0, 5'd0, 1'b1, '{1'b0, 10'd0, 13'sd4080, 1'b0}},
		'{1'b0, 8'd16, 8'd254, 8'(csel_pkg::POL_RISING), 12'd33, SH_STEP, 8'd0, 8'd255,
			12'd17, 12'd0, 5'd0, 1'b1, '{1'b1, 10'd0, 13'sd4080, 1'b0}},
		// Oversized half window clamps to the maximum; full-scale falling step.
		'{1'b0, 8'd31, 8'd0, 8'(csel_pkg::POL_FALLING), 12'd33, SH_STEP, 8'd255, 8'd0,
			12'd17, 12'd0, 5'd0, 1'b1, '{1'b1, 10'd0, -13'sd4080, 1'b0}},
		'{1'b0, 8'd17, 8'd0, 8'(csel_pkg::POL_EITHER), 12'd32, SH_NOISE, 8'd0, 8'd0, 12'd0,
			12'd0, 5'd0, 1'b1, '{1'b0, 10'd0, 13'sd0, 1'b1}},
		// Gradient equal to the scaled threshold does not pass.
		'{1'b0, 8'd2, 8'd50, 8'(csel_pkg::POL_EITHER), 12'd5, SH_STEP, 8'd0, 8'd50, 12'd2,
			12'd0, 5'd0, 1'b1, '{1'b0, 10'd0, 13'sd100, 1'b0}},
		// Unused polarity code, ties on a ramp, alternating pixels, a single spike.
		'{1'b0, 8'd3, 8'd10, 8'd3, 12'd40, SH_NOISE, 8'd0, 8'd0, 12'd0, 12'd0, 5'd0,
			1'b0, '0},
		'{1'b0, 8'd2, 8'd20, 8'(csel_pkg::POL_RISING), 12'd20, SH_RAMP, 8'd5, 8'd3, 12'd0,
			12'd0, 5'd0, 1'b0, '0},
		'{1'b0, 8'd4, 8'd60, 8'(csel_pkg::POL_FALLING), 12'd30, SH_ALT, 8'd0, 8'd255, 12'd0,
			12'd0, 5'd0, 1'b0, '0},
		'{1'b0, 8'd1, 8'd100, 8'(csel_pkg::POL_EITHER), 12'd25, SH_SPIKE, 8'd128, 8'd0,
			12'd12, 12'd0, 5'd0, 1'b0, '0},
		// Long profile: a step just past the searched length is never seen.
		'{1'b0, 8'd1, 8'd5, 8'(csel_pkg::POL_RISING), 12'd1026, SH_STEP, 8'd0, 8'd200,
			12'd1024, 12'd0, 5'd0, 1'b1, '{1'b0, 10'd0, 13'sd0, 1'b0}},
		// Half window changed in the middle of a profile.
		'{1'b0, 8'd2, 8'd3, 8'(csel_pkg::POL_EITHER), 12'd40, SH_NOISE, 8'd0, 8'd0, 12'd0,
			12'd20, 5'd6, 1'b0, '0},
		'{1'b0, 8'd8, 8'd0, 8'(csel_pkg::POL_FALLING), 12'd50, SH_NOISE, 8'd0, 8'd0, 12'd0,
			12'd25, 5'd1, 1'b0, '0},
		'{1'b0, 8'd16, 8'd255, 8'(csel_pkg::POL_EITHER), 12'd60, SH_NOISE, 8'd0, 8'd0, 12'd0,
			12'd0, 5'd0, 1'b0, '0},
		'{1'b0, 8'd5, 8'd128, 8'd3, 12'd45, SH_NSTEP, 8'd30, 8'd220, 12'd20, 12'd0, 5'd0,
			1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [csel_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [csel_pkg::CFG_DATA_W-1:0] cfg_data;

	csel_in_if  pix_ch ();
	csel_out_if res_ch ();

	caliper_step_edge_locator #(
		.MAX_HALF_WINDOW(MAX_HW),
		.MAX_PROFILE_LEN(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix(pix_ch),
		.res(res_ch)
	);

	// Model state: registers and the profile being searched.
	logic [csel_pkg::HW_CFG_W-1:0] hw_reg;
	logic [csel_pkg::THR_W-1:0]    thr_reg;
	logic [csel_pkg::POL_W-1:0]    pol_reg;
	logic [7:0]                    pix_win [0:WIN_D-1];
	int                            pix_count;
	int                            best_grad;
	int                            best_off;
	bit                            best_ok;

	edge_res_t pending_edges [$];
	int        mismatch_count = 0;
	bit        src_idle = 1'b0;
	bit        snk_idle = 1'b0;
	bit        hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic note_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	function automatic int abs_int(input int v);
		return (v < 0) ? -v : v;
	endfunction

	task automatic clear_profile();
		for (int j = 0; j < WIN_D; j++)
			pix_win[j] = 8'd0;
		pix_count = 0;
		best_grad = 0;
		best_off = 0;
		best_ok = 1'b0;
	endtask

	// Shift one pixel into the model window, update the extreme and, on the
	// last pixel, produce the profile result.
	task automatic locate_step(input logic [csel_pkg::SAMPLE_W-1:0] px, input logic tail,
		output bit emitted, output edge_res_t r);
		int h;
		int g;
		int thr;
		int j;
		logic [csel_pkg::POL_W-1:0] pol;
		bit take;
		bit found;
		h = int'(hw_reg);
		if (h < 1)
			h = 1;
		if (h > MAX_HW)
			h = MAX_HW;
		pol = (pol_reg == csel_pkg::POL_RISING || pol_reg == csel_pkg::POL_FALLING) ?
			pol_reg : csel_pkg::POL_EITHER;
		for (j = WIN_D - 1; j > 0; j--)
			pix_win[j] = pix_win[j-1];
		pix_win[0] = px;
		emitted = 1'b0;
		r = '0;

		// Only the first MAX_LEN pixels of a profile hold searchable centres.
		if (pix_count < MAX_LEN) begin
			if (pix_count >= 2 * h) begin
				g = 0;
				for (j = 0; j < h; j++)
					g += int'(pix_win[j]) - int'(pix_win[j+h+1]);
				if (!best_ok)
					take = 1'b1;
				else if (pol == csel_pkg::POL_RISING)
					take = g > best_grad;
				else if (pol == csel_pkg::POL_FALLING)
					take = g < best_grad;
				else
					take = abs_int(g) > abs_int(best_grad);
				if (take) begin
					best_grad = g;
					best_off = pix_count - 2 * h;
					best_ok = 1'b1;
				end
			end
			pix_count++;
		end

		if (tail) begin
			emitted = 1'b1;
			if (!best_ok) begin
				r.too_short = 1'b1;
			end else begin
				thr = h * int'(thr_reg);
				if (pol == csel_pkg::POL_RISING)
					found = best_grad > thr;
				else if (pol == csel_pkg::POL_FALLING)
					found = best_grad < -thr;
				else
					found = abs_int(best_grad) > thr;
				r.edge_found = found;
				r.edge_offset = best_off[csel_pkg::OFFSET_W-1:0];
				r.peak_gradient = best_grad[csel_pkg::GRAD_W-1:0];
			end
			clear_profile();
		end
	endtask

	function automatic logic [7:0] shape_sample(input shape_t shape, input logic [7:0] a,
		input logic [7:0] b, input logic [11:0] pos, input int i);
		int v;
		case (shape)
			SH_FLAT: v = int'(a);
			SH_STEP: v = (i < int'(pos)) ? int'(a) : int'(b);
			SH_NOISE: v = $urandom_range(0, 255);
			SH_RAMP: v = (int'(a) + i * int'(b)) % 256;
			SH_ALT: v = (i % 2 != 0) ? int'(b) : int'(a);
			SH_SPIKE: v = (i == int'(pos)) ? int'(b) : int'(a);
			SH_NSTEP: begin
				v = ((i < int'(pos)) ? int'(a) : int'(b)) + $urandom_range(0, 16) - 8;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
			end
			default: v = 0;
		endcase
		return v[7:0];
	endfunction

	// Offer one pixel, after a random gap when the source may idle, and wait for it to be taken.
	task automatic push_sample(input logic [csel_pkg::SAMPLE_W-1:0] px, input logic tail,
		input logic typed, input edge_res_t want);
		int gap;
		bit emitted;
		edge_res_t calc;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.sample <= px;
		pix_ch.last <= tail;
		do @(posedge clk); while (!pix_ch.ready);
		locate_step(px, tail, emitted, calc);
		if (emitted)
			pending_edges.insert(pending_edges.size(), typed ? want : calc);
	endtask

	// Stop offering, wait for every outstanding result, then let the pipeline drain.
	task automatic settle();
		pix_ch.valid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [csel_pkg::CFG_IDX_W-1:0] idx,
		input logic [csel_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == csel_pkg::REG_HALF_WINDOW)
			hw_reg = data[csel_pkg::HW_CFG_W-1:0];
		else if (idx == csel_pkg::REG_STEP_THRESHOLD)
			thr_reg = data[csel_pkg::THR_W-1:0];
		else if (idx == csel_pkg::REG_POLARITY)
			pol_reg = data[csel_pkg::POL_W-1:0];
	endtask

	task automatic load_regs(input logic [7:0] hw_data, input logic [7:0] thr_data,
		input logic [7:0] pol_data);
		write_reg(csel_pkg::REG_HALF_WINDOW, hw_data);
		write_reg(csel_pkg::REG_STEP_THRESHOLD, thr_data);
		write_reg(csel_pkg::REG_POLARITY, pol_data);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_profile(input int len, input shape_t shape, input logic [7:0] a,
		input logic [7:0] b, input logic [11:0] pos, input int cut, input logic [4:0] cut_hw,
		input logic typed, input edge_res_t want);
		for (int i = 0; i < len; i++) begin
			push_sample(shape_sample(shape, a, b, pos, i), i == len - 1, typed, want);
			// Change the half window with the profile half done and the pipeline empty.
			if (cut != 0 && i == cut - 1) begin
				settle();
				write_reg(csel_pkg::REG_HALF_WINDOW, {3'b000, cut_hw});
				cfg_wr_en <= 1'b0;
			end
		end
	endtask

	function automatic int eff_half_window();
		if (hw_reg == '0)
			return 1;
		if (int'(hw_reg) > MAX_HW)
			return MAX_HW;
		return int'(hw_reg);
	endfunction

	// Result side: random ready gaps, one long hold on request, and the check.
	initial begin : result_sink
		int stall_left;
		int hold_left;
		edge_res_t got;
		edge_res_t want;
		stall_left = 0;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got = '{res_ch.edge_found, res_ch.edge_offset, res_ch.peak_gradient,
					res_ch.too_short};
				if (pending_edges.size() == 0) begin
					note_mismatch("result with none expected", int'(got.edge_offset), 0);
				end else begin
					want = pending_edges.pop_front();
					if (got.edge_found !== want.edge_found)
						note_mismatch("edge_found", int'(got.edge_found),
							int'(want.edge_found));
					if (got.edge_offset !== want.edge_offset)
						note_mismatch("edge_offset", int'(got.edge_offset),
							int'(want.edge_offset));
					if (got.peak_gradient !== want.peak_gradient)
						note_mismatch("peak_gradient", int'(got.peak_gradient),
							int'(want.peak_gradient));
					if (got.too_short !== want.too_short)
						note_mismatch("too_short", int'(got.too_short),
							int'(want.too_short));
				end
				stall_left = snk_idle ? $urandom_range(0, 15) : 0;
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus: reset, the directed table, then random phases.
	initial begin : pixel_source
		plan_row_t row;
		int sent;
		int phase;
		int nprof;
		int he;
		int len;
		int sel;
		logic [4:0] hw5;
		logic [7:0] thr_v;

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= csel_pkg::REG_HALF_WINDOW;
		cfg_data <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.sample <= '0;
		pix_ch.last <= 1'b0;
		hw_reg = csel_pkg::HALF_WINDOW_RESET;
		thr_reg = csel_pkg::STEP_THRESHOLD_RESET;
		pol_reg = csel_pkg::POLARITY_RESET;
		clear_profile();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_N; r++) begin
			row = PLAN[r];
			settle();
			src_idle = (r % 3 != 0);
			snk_idle = (r % 2 == 0);
			if (!row.keep_cfg)
				load_regs(row.hw_data, row.thr_data, row.pol_data);
			send_profile(int'(row.len), row.shape, row.lvl_a, row.lvl_b, row.pos,
				int'(row.cut), row.cut_hw, row.typed, row.want);
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_SAMPLES) begin
			settle();
			// Now and then a write to the spare index, which must change nothing.
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
			// Pick registers, biased toward their extremes and out-of-range codes.
			sel = $urandom_range(0, 5);
			case (sel)
				0: hw5 = 5'd0;
				1: hw5 = 5'd1;
				2: hw5 = 5'd16;
				3: hw5 = 5'($urandom_range(17, 31));
				default: hw5 = 5'($urandom_range(1, 16));
			endcase
			sel = $urandom_range(0, 4);
			thr_v = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(0, 255));
			load_regs({3'($urandom_range(0, 7)), hw5}, thr_v,
				{6'($urandom_range(0, 63)), 2'($urandom_range(0, 3))});
			src_idle = ($urandom_range(0, 2) != 0);
			snk_idle = ($urandom_range(0, 2) != 0);
			he = eff_half_window();
			nprof = $urandom_range(2, 8);

			// The first phase hammers short profiles into a receiver that holds off.
			if (phase == 0) begin
				hold_req = 1'b1;
				src_idle = 1'b0;
				for (int p = 0; p < 16; p++) begin
					len = $urandom_range(1, 2 * he + 3);
					send_profile(len, SH_NOISE, 8'd0, 8'd0, 12'd0, 0, 5'd0, 1'b0, '0);
					sent += len;
				end
			end

			for (int p = 0; p < nprof; p++) begin
				sel = $urandom_range(0, 9);
				if (sel < 8)
					len = 2 * he + 1 + $urandom_range(0, 40);
				else if (sel == 8)
					len = $urandom_range(1, 2 * he);
				else
					len = $urandom_range(2 * he + 1, 150);
				send_profile(len, shape_t'($urandom_range(0, 6)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 12'($urandom_range(0, len - 1)), 0, 5'd0,
					1'b0, '0);
				sent += len;
			end
			phase++;
		end

		settle();
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ caliper_step_edge_locator.f @@
+incdir+design
design/csel_pkg.sv
design/csel_if.sv
design/csel_grad.sv
design/caliper_step_edge_locator.sv
tb/tb_caliper_step_edge_locator.sv
